// ===== rtl/assert_macros.svh =====
// Assertion macros used by the RTL of the frame replacer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A condition that must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  `ASSERT_CLK(lbl, !(cond), msg)

`endif

// ===== rtl/lru_pkg.sv =====
// Package of widths, defaults and request codes for the frame replacer.
`timescale 1ns / 1ps
`default_nettype none

package lru_pkg;

  localparam int FID_W = 6;
  localparam int REQ_W = 2;
  localparam int CNT_W = 7;
  localparam int CAP_W = 7;

  localparam int NUM_FRAMES_DEF = 64;
  localparam logic [CAP_W-1:0] CAPACITY_RST = 7'd64;

  typedef logic [REQ_W-1:0] req_t;

  localparam req_t REQ_VICTIM = 2'd0;
  localparam req_t REQ_PIN    = 2'd1;
  localparam req_t REQ_UNPIN  = 2'd2;

endpackage

`default_nettype wire

// ===== rtl/lru_frame_replacer.sv =====
// An accepted word is held in the working stage; its result, marked by done, is registered.
// Throughput: one word per cycle; the link RAM reads are issued as the word is accepted
// and the writes of the word ahead are forwarded, so the list update is a single pass.
// Reset is synchronous: it clears the presence flags, head, tail, occupancy and capacity
// (to 64); busy stays high until an edge sees reset low. Link RAMs are not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module lru_frame_replacer
  import lru_pkg::*;
#(
  parameter int NUM_FRAMES = NUM_FRAMES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output      logic             busy,
  input  wire logic [REQ_W-1:0] req_type,
  input  wire logic [FID_W-1:0] frame_num,
  input  wire logic             cfg_we,
  input  wire logic [CAP_W-1:0] cfg_wdata,
  output      logic             done,
  output      logic             op_ok,
  output      logic [FID_W-1:0] victim_frame,
  output      logic             evicted_valid,
  output      logic [FID_W-1:0] evicted_frame,
  output      logic [CNT_W-1:0] occupancy
);

  localparam int IDX_W   = $clog2(NUM_FRAMES);
  localparam int CAP_TOP = (1 << CAP_W) - 1;
  localparam int CAP_MAX = (NUM_FRAMES < CAP_TOP) ? NUM_FRAMES : CAP_TOP;

  function automatic logic [IDX_W-1:0] to_idx(input logic [FID_W-1:0] f);
    logic [IDX_W+FID_W-1:0] w;
    w = {{IDX_W{1'b0}}, f};
    return w[IDX_W-1:0];
  endfunction

  function automatic logic [FID_W-1:0] to_fid(input logic [IDX_W-1:0] i);
    logic [IDX_W+FID_W-1:0] w;
    w = {{FID_W{1'b0}}, i};
    return w[FID_W-1:0];
  endfunction

  // Architectural state.
  logic [NUM_FRAMES-1:0] present;
  logic [IDX_W-1:0]      most_recent;
  logic [IDX_W-1:0]      least_recent;
  logic [CNT_W-1:0]      count;
  logic [CAP_W-1:0]      capacity;

  // Working stage: the word accepted at the previous edge.
  logic             act;
  req_t             s_req;
  logic             s_in_pool;
  logic [IDX_W-1:0] s_fi;

  // Link RAM ports and forwarding registers.
  logic             nwe, owe;
  logic [IDX_W-1:0] nwa, owa, nwd, owd;
  logic [IDX_W-1:0] n_raddr, o_raddr;
  logic [IDX_W-1:0] n_rdata, o_rdata;
  logic             byp_n_hit, byp_o_hit;
  logic [IDX_W-1:0] byp_n_data, byp_o_data;
  logic [IDX_W-1:0] newer_rd, older_rd;

  // Next-state values.
  logic [NUM_FRAMES-1:0] present_next;
  logic [IDX_W-1:0]      most_recent_next;
  logic [IDX_W-1:0]      least_recent_next;
  logic [CNT_W-1:0]      count_next;
  logic                  ok_next, evv_next;
  logic [IDX_W-1:0]      vic_next, evf_next;
  logic [CNT_W-1:0]      c1;
  logic [CAP_W-1:0]      cap_lo, cap_eff;
  logic                  accept;
  logic [IDX_W-1:0]      fi_in;

  assign accept = start && !busy;
  assign fi_in  = to_idx(frame_num);

  lru_ram #(.WIDTH(IDX_W), .DEPTH(NUM_FRAMES)) u_newer_ram (
    .clk   (clk),
    .we    (nwe),
    .waddr (nwa),
    .wdata (nwd),
    .raddr (n_raddr),
    .rdata (n_rdata)
  );

  lru_ram #(.WIDTH(IDX_W), .DEPTH(NUM_FRAMES)) u_older_ram (
    .clk   (clk),
    .we    (owe),
    .waddr (owa),
    .wdata (owd),
    .raddr (o_raddr),
    .rdata (o_rdata)
  );

  assign newer_rd = byp_n_hit ? byp_n_data : n_rdata;
  assign older_rd = byp_o_hit ? byp_o_data : o_rdata;

  // A capacity of zero acts as one, and anything above the pool size as the pool size.
  always_comb begin
    cap_lo  = (capacity == '0) ? CAP_W'(1) : capacity;
    cap_eff = (32'(cap_lo) > CAP_MAX) ? CAP_W'(CAP_MAX) : cap_lo;
  end

  always_comb begin
    present_next      = present;
    most_recent_next  = most_recent;
    least_recent_next = least_recent;
    count_next        = count;
    ok_next           = 1'b0;
    evv_next          = 1'b0;
    vic_next          = '0;
    evf_next          = '0;
    c1                = count;
    nwe               = 1'b0;
    nwa               = '0;
    nwd               = '0;
    owe               = 1'b0;
    owa               = '0;
    owd               = '0;
    if (act) begin
      case (s_req)
        REQ_VICTIM: begin
          if (count != '0) begin
            ok_next                    = 1'b1;
            vic_next                   = least_recent;
            present_next[least_recent] = 1'b0;
            if (count <= CNT_W'(1)) begin
              count_next = '0;
            end else begin
              least_recent_next = newer_rd;
              count_next        = count - CNT_W'(1);
            end
          end
        end
        REQ_PIN: begin
          if (s_in_pool && present[s_fi]) begin
            ok_next            = 1'b1;
            present_next[s_fi] = 1'b0;
            if (count <= CNT_W'(1)) begin
              count_next = '0;
            end else begin
              count_next = count - CNT_W'(1);
              if (s_fi == most_recent) begin
                most_recent_next = older_rd;
              end else if (s_fi == least_recent) begin
                least_recent_next = newer_rd;
              end else begin
                // Bridge the neighbours of a frame from the middle of the order.
                owe = 1'b1;
                owa = newer_rd;
                owd = older_rd;
                nwe = 1'b1;
                nwa = older_rd;
                nwd = newer_rd;
              end
            end
          end
        end
        REQ_UNPIN: begin
          if (s_in_pool && !present[s_fi]) begin
            ok_next = 1'b1;
            if (count >= cap_eff && count != '0) begin
              evv_next                   = 1'b1;
              evf_next                   = least_recent;
              present_next[least_recent] = 1'b0;
              if (count <= CNT_W'(1)) begin
                c1 = '0;
              end else begin
                least_recent_next = newer_rd;
                c1                = count - CNT_W'(1);
              end
            end
            if (c1 == '0) begin
              most_recent_next  = s_fi;
              least_recent_next = s_fi;
            end else begin
              owe              = 1'b1;
              owa              = s_fi;
              owd              = most_recent;
              nwe              = 1'b1;
              nwa              = most_recent;
              nwd              = s_fi;
              most_recent_next = s_fi;
            end
            present_next[s_fi] = 1'b1;
            count_next         = c1 + CNT_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // The word being accepted reads the links against the state this cycle leaves behind.
  assign n_raddr = (req_type == REQ_PIN) ? fi_in : least_recent_next;
  assign o_raddr = fi_in;

  always_ff @(posedge clk) begin
    byp_n_hit  <= nwe && (nwa == n_raddr);
    byp_n_data <= nwd;
    byp_o_hit  <= owe && (owa == o_raddr);
    byp_o_data <= owd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b1;
      act          <= 1'b0;
      done         <= 1'b0;
      present      <= '0;
      most_recent  <= '0;
      least_recent <= '0;
      count        <= '0;
      capacity     <= CAPACITY_RST;
    end else begin
      busy         <= 1'b0;
      act          <= accept;
      done         <= act;
      present      <= present_next;
      most_recent  <= most_recent_next;
      least_recent <= least_recent_next;
      count        <= count_next;
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_req     <= req_type;
      s_in_pool <= 32'(frame_num) < NUM_FRAMES;
      s_fi      <= fi_in;
    end
    op_ok         <= ok_next;
    victim_frame  <= to_fid(vic_next);
    evicted_valid <= evv_next;
    evicted_frame <= to_fid(evf_next);
    occupancy     <= count_next;
  end

  `ASSERT_CLK(a_done_follows_accept, done |-> $past(start && !busy && !rst, 2), "done without an accepted word")
  `ASSERT_CLK(a_count_matches_flags, 32'(count) == $countones(present), "occupancy differs from presence flags")
  `ASSERT_CLK(a_head_present, (count != '0) |-> present[most_recent], "head frame is not marked present")
  `ASSERT_NEVER(a_evict_without_insert, done && evicted_valid && !op_ok, "eviction reported without an insert")

endmodule

`default_nettype wire

// ===== rtl/lru_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module lru_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== verif/lru_frame_replacer_tb.sv =====
// Self-checking testbench for the LRU frame replacer: directed and random request words.
`timescale 1ns / 1ps

module lru_frame_replacer_tb
  import lru_pkg::*;
();

  localparam int          FRAMES      = NUM_FRAMES_DEF;
  localparam int unsigned CYCLE_LIMIT = 300000;
  // The package names only the three defined request codes.
  localparam req_t        REQ_UNDEFINED = 2'd3;

  typedef struct packed {
    logic             op_ok;
    logic [FID_W-1:0] victim_frame;
    logic             evicted_valid;
    logic [FID_W-1:0] evicted_frame;
    logic [CNT_W-1:0] occupancy;
  } replacer_reply_t;

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  req_t             req_type;
  logic [FID_W-1:0] frame_num;
  logic             cfg_we;
  logic [CAP_W-1:0] cfg_wdata;
  logic             done;
  logic             op_ok;
  logic [FID_W-1:0] victim_frame;
  logic             evicted_valid;
  logic [FID_W-1:0] evicted_frame;
  logic [CNT_W-1:0] occupancy;

  // Expected recency order, kept as a doubly linked list like the block's own.
  logic             lru_present [FRAMES];
  logic [FID_W-1:0] lru_newer   [FRAMES];
  logic [FID_W-1:0] lru_older   [FRAMES];
  logic [FID_W-1:0] lru_head;
  logic [FID_W-1:0] lru_tail;
  int unsigned      lru_count;
  logic [CAP_W-1:0] lru_capacity;

  replacer_reply_t  pending_replies[$];
  int unsigned      mismatch_count;
  int unsigned      cycle_count;
  int unsigned      sender_idle_pct;

  lru_frame_replacer #(.NUM_FRAMES(FRAMES)) u_top (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .req_type      (req_type),
    .frame_num     (frame_num),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .done          (done),
    .op_ok         (op_ok),
    .victim_frame  (victim_frame),
    .evicted_valid (evicted_valid),
    .evicted_frame (evicted_frame),
    .occupancy     (occupancy)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void lru_clear();
    for (int i = 0; i < FRAMES; i++) begin
      lru_present[i] = 1'b0;
      lru_newer[i]   = '0;
      lru_older[i]   = '0;
    end
    lru_head     = '0;
    lru_tail     = '0;
    lru_count    = 0;
    lru_capacity = CAPACITY_RST;
  endfunction

  function automatic void lru_unlink(logic [FID_W-1:0] f);
    logic [FID_W-1:0] nw;
    logic [FID_W-1:0] od;
    nw = lru_newer[f];
    od = lru_older[f];
    if (lru_count <= 1) begin
      lru_count = 0;
    end else if (f == lru_head) begin
      lru_head = od;
      lru_count--;
    end else if (f == lru_tail) begin
      lru_tail = nw;
      lru_count--;
    end else begin
      lru_older[nw] = od;
      lru_newer[od] = nw;
      lru_count--;
    end
    lru_present[f] = 1'b0;
  endfunction

  function automatic void lru_link_head(logic [FID_W-1:0] f);
    if (lru_count == 0) begin
      lru_head = f;
      lru_tail = f;
    end else begin
      lru_older[f]        = lru_head;
      lru_newer[lru_head] = f;
      lru_head            = f;
    end
    lru_present[f] = 1'b1;
    lru_count++;
  endfunction

  // Applies one request word to the expected order and returns the reply it must give.
  function automatic replacer_reply_t apply_request(req_t kind, logic [FID_W-1:0] f);
    replacer_reply_t reply;
    int unsigned     cap_eff;
    reply   = '0;
    cap_eff = lru_capacity;
    if (cap_eff == 0) cap_eff = 1;
    if (cap_eff > FRAMES) cap_eff = FRAMES;
    case (kind)
      REQ_VICTIM: begin
        if (lru_count != 0) begin
          reply.victim_frame = lru_tail;
          lru_unlink(lru_tail);
          reply.op_ok = 1'b1;
        end
      end
      REQ_PIN: begin
        if (lru_present[f]) begin
          lru_unlink(f);
          reply.op_ok = 1'b1;
        end
      end
      REQ_UNPIN: begin
        if (!lru_present[f]) begin
          if (lru_count >= cap_eff && lru_count != 0) begin
            reply.evicted_frame = lru_tail;
            reply.evicted_valid = 1'b1;
            lru_unlink(lru_tail);
          end
          lru_link_head(f);
          reply.op_ok = 1'b1;
        end
      end
      default: ;
    endcase
    reply.occupancy = lru_count[CNT_W-1:0];
    return reply;
  endfunction

  function automatic logic [FID_W-1:0] pick_present_frame();
    logic [FID_W-1:0] base;
    logic [FID_W-1:0] probe;
    base = FID_W'($urandom_range(FRAMES - 1));
    for (int i = 0; i < FRAMES; i++) begin
      probe = base + FID_W'(i);
      if (lru_present[probe]) return probe;
    end
    return base;
  endfunction

  function automatic void check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatch_count++;
    end
  endfunction

  // Called at a falling edge; returns at a falling edge with start still high, so that a
  // following word can be presented without start dropping in between.
  task automatic send_request(input req_t kind, input logic [FID_W-1:0] fid);
    int unsigned gap;
    gap = 0;
    if (sender_idle_pct != 0)
      while ($urandom_range(99) < sender_idle_pct && gap < 12) gap++;
    if (gap != 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start     = 1'b1;
    req_type  = kind;
    frame_num = fid;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_replies.push_back(apply_request(kind, fid));
    @(negedge clk);
  endtask

  task automatic hold_until_drained();
    start = 1'b0;
    while (pending_replies.size() != 0) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] value);
    hold_until_drained();
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we       = 1'b0;
    lru_capacity = value;
  endtask

  always @(posedge clk) begin
    replacer_reply_t want;
    if (!rst && done) begin
      if (pending_replies.size() == 0) begin
        $error("result word with no request outstanding");
        mismatch_count++;
      end else begin
        want = pending_replies.pop_front();
        check_field("op_ok", 8'(want.op_ok), 8'(op_ok));
        check_field("victim_frame", 8'(want.victim_frame), 8'(victim_frame));
        check_field("evicted_valid", 8'(want.evicted_valid), 8'(evicted_valid));
        check_field("evicted_frame", 8'(want.evicted_frame), 8'(evicted_frame));
        check_field("occupancy", 8'(want.occupancy), 8'(occupancy));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic test_empty_and_codes();
    send_request(REQ_VICTIM, 6'd0);
    send_request(REQ_UNPIN, 6'd0);
    send_request(REQ_UNPIN, 6'd63);
    send_request(REQ_UNPIN, 6'd0);
    send_request(REQ_PIN, 6'd7);
    send_request(REQ_PIN, 6'd63);
    send_request(REQ_UNDEFINED, 6'd63);
    send_request(REQ_VICTIM, 6'd42);
    send_request(REQ_VICTIM, 6'd63);
  endtask

  task automatic test_capacity_extremes();
    // A capacity of zero behaves as one, so the second unpin evicts the first frame.
    write_capacity(7'd0);
    send_request(REQ_UNPIN, 6'd1);
    send_request(REQ_UNPIN, 6'd2);
    write_capacity(7'd1);
    send_request(REQ_UNPIN, 6'd3);
    send_request(REQ_VICTIM, 6'd0);
  endtask

  task automatic test_shrink_below_occupancy();
    write_capacity(7'd64);
    for (int i = 10; i < 16; i++) send_request(REQ_UNPIN, FID_W'(i));
    send_request(REQ_PIN, 6'd12);
    // The sender waits here for every word in flight before the capacity drops.
    hold_until_drained();
    write_capacity(7'd2);
    send_request(REQ_UNPIN, 6'd20);
    send_request(REQ_VICTIM, 6'd0);
  endtask

  task automatic test_random_traffic(input int unsigned phase, input int unsigned words);
    int unsigned      unpin_pct;
    int unsigned      roll;
    logic [CAP_W-1:0] caps [4];
    int unsigned      idles [4];
    int unsigned      unpins [4];
    caps   = '{7'd64, 7'd127, 7'd6, 7'd33};
    // The sender leaves gaps only in the second and fourth phases; the receiver cannot hold results off.
    idles  = '{0, 55, 0, 29};
    unpins = '{70, 75, 50, 55};
    write_capacity(caps[phase]);
    sender_idle_pct = idles[phase];
    unpin_pct       = unpins[phase];
    for (int n = 0; n < words; n++) begin
      roll = $urandom_range(99);
      if (roll < unpin_pct)
        send_request(REQ_UNPIN, FID_W'($urandom_range(FRAMES - 1)));
      else if (roll < unpin_pct + 22)
        send_request(REQ_PIN, ($urandom_range(9) < 7) ? pick_present_frame()
                                                      : FID_W'($urandom_range(FRAMES - 1)));
      else if (roll < 97)
        send_request(REQ_VICTIM, FID_W'($urandom_range(FRAMES - 1)));
      else
        send_request(REQ_UNDEFINED, FID_W'($urandom_range(FRAMES - 1)));
    end
    sender_idle_pct = 0;
  endtask

  initial begin
    rst             = 1'b1;
    start           = 1'b0;
    req_type        = REQ_VICTIM;
    frame_num       = '0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    mismatch_count  = 0;
    cycle_count     = 0;
    sender_idle_pct = 0;
    lru_clear();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);

    test_empty_and_codes();
    test_capacity_extremes();
    test_shrink_below_occupancy();
    for (int p = 0; p < 4; p++) test_random_traffic(p, 120);

    hold_until_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
